@@ design/vau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic unit package
// Shared constants, command codes and port widths of the vector unit.
// ----------------------------------------------------------------------------
package vau_pkg;

   // fixed-point format of every component
   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   // equality tolerance register
   localparam int TOL_BITS = 31;
   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);

   // port widths
   localparam int CMD_BITS      = 4;
   localparam int REQ_DATA_BITS = 7 * WORD_BITS;
   localparam int RSP_DATA_BITS = 4 * WORD_BITS;
   localparam int RSP_USER_BITS = 2;

   // flag positions in the result tuser
   localparam int USER_EQ_BIT  = 0;
   localparam int USER_ERR_BIT = 1;

   // iteration counts of the root and divide pipelines
   localparam int SQ_STEPS  = WORD_BITS;
   localparam int DV_STEPS  = WORD_BITS - 1;
   localparam int PIPE_LAST = SQ_STEPS + DV_STEPS + 1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD    = 4'd0,
      CMD_SUB    = 4'd1,
      CMD_SCALE  = 4'd2,
      CMD_DIV    = 4'd3,
      CMD_DOT    = 4'd4,
      CMD_CROSS  = 4'd5,
      CMD_SQMAG  = 4'd6,
      CMD_MAG    = 4'd7,
      CMD_NORM   = 4'd8,
      CMD_EQUAL  = 4'd9
   } cmd_type;

endpackage

@@ design/vector3_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-component vector arithmetic unit
// Fixed-point vector add, subtract, scale, divide, dot, cross, squared
// magnitude, magnitude, normalize and tolerance compare.
// ----------------------------------------------------------------------------
// Usage:
//  - Request words carry a command on req_tuser and vectors a, b and a
//    scalar on req_tdata; each request word gives exactly one response word.
//  - Response words carry the result vector and scalar on rsp_tdata and the
//    equal and error flags on rsp_tuser.
//  - csr_wr_en writes the equality tolerance; write it only while idle.
//  - An accepted request passes the operand, multiply and combine stages,
//    the root-pipe load stage, the square-root stages (one root bit per stage),
//    a divisor set-up stage, the division stages (one quotient bit per
//    stage) and the output register before its response is shown.
//  - Throughput is one word per cycle while the output is not held; every command runs the full pipe.
//  - The whole pipe holds while the output register is full and rsp_tready
//    is low; req_tready drops for that cycle and nothing is lost.
//  - Reset clears all valid bits and sets the tolerance to one LSB.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request: ax, ay, az, bx, by, bz, scalar_in (32 bits each, lowest first)
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vau_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // request kind: cmd
   input  logic [vau_pkg::CMD_BITS-1:0]       req_tuser,
   // response: rx, ry, rz, scalar_out (32 bits each, lowest first)
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vau_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // response flags: is_equal, error
   output logic [vau_pkg::RSP_USER_BITS-1:0]  rsp_tuser,
   // tolerance register
   input  logic                               csr_wr_en,
   input  logic [vau_pkg::TOL_BITS-1:0]       csr_wr_data
);

   localparam int W  = vau_pkg::WORD_BITS;
   localparam int FB = vau_pkg::FRAC_BITS;
   localparam int PW = 2 * W;            // full product
   localparam int FW = PW - FB + 2;      // floored product sums
   localparam int SL = vau_pkg::SQ_STEPS;
   localparam int DL = vau_pkg::DV_STEPS;
   localparam int PL = vau_pkg::PIPE_LAST;

   typedef struct packed {
      logic [vau_pkg::CMD_BITS-1:0] cmd;
      logic [2:0][W-1:0]            a;
      logic [2:0][W-1:0]            b;
      logic [W-1:0]                 s;
   } in_type;

   typedef struct packed {
      logic [vau_pkg::CMD_BITS-1:0] cmd;
      logic [2:0][W-1:0]            vec;
      logic [W-1:0]                 sc;
      logic                         eq;
      logic                         err;
      logic [2:0][W-1:0]            amag;
      logic [2:0]                   aneg;
      logic [W-1:0]                 smag;
      logic                         sneg;
   } ctl_type;

   typedef struct packed {
      logic [W+1:0]  rem;
      logic [W-1:0]  root;
      logic [PW-1:0] rad;
   } sq_type;

   typedef struct packed {
      logic [W-1:0]            d;
      logic [2:0]              ovf;
      logic [2:0]              neg;
      logic [2:0][W-1:0]       rem;
      logic [2:0][W-2:0]       q;
      logic [2:0][W-2:0]       lo;
   } dv_type;

   // saturate a wide signed value to one word
   function automatic logic [W-1:0] sat_word(logic signed [FW-1:0] v);
      logic fits;
      fits = (&v[FW-1:W-1]) || ~(|v[FW-1:W-1]);
      if (fits) return v[W-1:0];
      else if (v[FW-1]) return {1'b1, {(W-1){1'b0}}};
      else return {1'b0, {(W-1){1'b1}}};
   endfunction

   // one bit of the digit-by-digit square root
   function automatic sq_type sq_step(sq_type s);
      logic [W+3:0] cur;
      logic [W+3:0] trial;
      sq_type       r;
      cur   = {s.rem, s.rad[PW-1:PW-2]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[PW-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = (W+2)'(cur - trial);
         r.root = {s.root[W-2:0], 1'b1};
      end else begin
         r.rem  = cur[W+1:0];
         r.root = {s.root[W-2:0], 1'b0};
      end
      return r;
   endfunction

   // one quotient bit of the three restoring divisions
   function automatic dv_type dv_step(dv_type s);
      logic [W:0] cur;
      dv_type     r;
      r = s;
      for (int i = 0; i < 3; i++) begin
         cur      = {s.rem[i], s.lo[i][W-2]};
         r.lo[i]  = {s.lo[i][W-3:0], 1'b0};
         if (cur >= {1'b0, s.d}) begin
            r.rem[i] = W'(cur - {1'b0, s.d});
            r.q[i]   = {s.q[i][W-3:0], 1'b1};
         end else begin
            r.rem[i] = cur[W-1:0];
            r.q[i]   = {s.q[i][W-3:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic                   en;
   logic [vau_pkg::TOL_BITS-1:0] tol_ff;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   in_type                 in1_ff;
   ctl_type                ctl2_in, ctl2_ff, ctl3_in, ctl3_ff, ctl4_ff;
   logic [5:0][W-1:0]      ma2_in, mb2_in, ma2_ff, mb2_ff;
   logic [2:0][W-1:0]      adf2_in, adf2_ff;
   logic [5:0][PW-1:0]     prod3_ff;
   logic [2:0][FW-1:0]     fv4_in, fv4_ff;
   logic [FW-1:0]          fdot4_in, fdot4_ff;
   logic [PW-1:0]          rad4_in, rad4_ff;

   ctl_type                p0_in;
   logic [PL:0]            vp_ff;
   ctl_type                ctlp_ff [0:PL];
   sq_type                 sq_ff   [0:SL];
   dv_type                 dv_ff   [0:DL];
   ctl_type                d0_in;
   dv_type                 dv0_in;

   logic                   rsp_valid_ff;
   logic [2:0][W-1:0]      rvec_in, rvec_ff;
   logic [W-1:0]           rsc_ff;
   logic                   req_ff, rerr_ff;

   // whole pipe advances unless the output word is held
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= vau_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // stage 1: register the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in1_ff.cmd <= req_tuser;
         for (int i = 0; i < 3; i++) begin
            in1_ff.a[i] <= req_tdata[i*W +: W];
            in1_ff.b[i] <= req_tdata[(i+3)*W +: W];
         end
         in1_ff.s <= req_tdata[6*W +: W];
      end
   end

   // stage 2: operand routing, add/sub, magnitudes
   always_comb begin
      logic [W:0] sum;
      logic [W:0] dif;
      logic [W:0] neg;
      ctl2_in     = '0;
      ctl2_in.cmd = in1_ff.cmd;
      ma2_in      = '0;
      mb2_in      = '0;
      for (int i = 0; i < 3; i++) begin
         sum = {in1_ff.a[i][W-1], in1_ff.a[i]} + {in1_ff.b[i][W-1], in1_ff.b[i]};
         dif = {in1_ff.a[i][W-1], in1_ff.a[i]} - {in1_ff.b[i][W-1], in1_ff.b[i]};
         neg = {1'b0, {W{1'b0}}} - {in1_ff.a[i][W-1], in1_ff.a[i]};
         adf2_in[i] = dif[W] ? W'(-dif) : dif[W-1:0];
         ctl2_in.amag[i] = in1_ff.a[i][W-1] ? neg[W-1:0] : in1_ff.a[i];
         ctl2_in.aneg[i] = in1_ff.a[i][W-1];
         if (in1_ff.cmd == vau_pkg::CMD_ADD) begin
            ctl2_in.vec[i] = sat_word(FW'($signed(sum)));
         end else if (in1_ff.cmd == vau_pkg::CMD_SUB) begin
            ctl2_in.vec[i] = sat_word(FW'($signed(dif)));
         end
      end
      neg = {1'b0, {W{1'b0}}} - {in1_ff.s[W-1], in1_ff.s};
      ctl2_in.smag = in1_ff.s[W-1] ? neg[W-1:0] : in1_ff.s;
      ctl2_in.sneg = in1_ff.s[W-1];
      ctl2_in.err  = (in1_ff.cmd == vau_pkg::CMD_DIV) && (in1_ff.s == '0);
      case (in1_ff.cmd)
         vau_pkg::CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               ma2_in[2*i] = in1_ff.a[i];
               mb2_in[2*i] = in1_ff.s;
            end
         end
         vau_pkg::CMD_DOT: begin
            for (int i = 0; i < 3; i++) begin
               ma2_in[2*i] = in1_ff.a[i];
               mb2_in[2*i] = in1_ff.b[i];
            end
         end
         vau_pkg::CMD_CROSS: begin
            ma2_in[0] = in1_ff.a[1];  mb2_in[0] = in1_ff.b[2];
            ma2_in[1] = in1_ff.a[2];  mb2_in[1] = in1_ff.b[1];
            ma2_in[2] = in1_ff.a[2];  mb2_in[2] = in1_ff.b[0];
            ma2_in[3] = in1_ff.a[0];  mb2_in[3] = in1_ff.b[2];
            ma2_in[4] = in1_ff.a[0];  mb2_in[4] = in1_ff.b[1];
            ma2_in[5] = in1_ff.a[1];  mb2_in[5] = in1_ff.b[0];
         end
         vau_pkg::CMD_SQMAG, vau_pkg::CMD_MAG, vau_pkg::CMD_NORM: begin
            for (int i = 0; i < 3; i++) begin
               ma2_in[2*i] = in1_ff.a[i];
               mb2_in[2*i] = in1_ff.a[i];
            end
         end
         default: begin
            ma2_in = '0;
            mb2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl2_ff <= ctl2_in;
         ma2_ff  <= ma2_in;
         mb2_ff  <= mb2_in;
         adf2_ff <= adf2_in;
      end
   end

   // stage 3: six signed multipliers and the tolerance compare
   always_comb begin
      ctl3_in    = ctl2_ff;
      ctl3_in.eq = (ctl2_ff.cmd == vau_pkg::CMD_EQUAL);
      for (int i = 0; i < 3; i++) begin
         if (adf2_ff[i] > {1'b0, tol_ff}) ctl3_in.eq = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl3_ff <= ctl3_in;
         for (int k = 0; k < 6; k++) begin
            prod3_ff[k] <= $signed(ma2_ff[k]) * $signed(mb2_ff[k]);
         end
      end
   end

   // stage 4: floor the products and combine them
   always_comb begin
      logic signed [PW-FB-1:0] f [0:5];
      for (int k = 0; k < 6; k++) begin
         f[k] = (PW-FB)'($signed(prod3_ff[k]) >>> FB);
      end
      for (int i = 0; i < 3; i++) begin
         if (ctl3_ff.cmd == vau_pkg::CMD_CROSS) begin
            fv4_in[i] = FW'(f[2*i]) - FW'(f[2*i+1]);
         end else begin
            fv4_in[i] = FW'(f[2*i]);
         end
      end
      fdot4_in = FW'(f[0]) + FW'(f[2]) + FW'(f[4]);
      rad4_in  = prod3_ff[0] + prod3_ff[2] + prod3_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl4_ff  <= ctl3_ff;
         fv4_ff   <= fv4_in;
         fdot4_ff <= fdot4_in;
         rad4_ff  <= rad4_in;
      end
   end

   // stage 5: saturate product results, load the root pipe
   always_comb begin
      p0_in = ctl4_ff;
      case (ctl4_ff.cmd)
         vau_pkg::CMD_SCALE, vau_pkg::CMD_CROSS: begin
            for (int i = 0; i < 3; i++) p0_in.vec[i] = sat_word(fv4_ff[i]);
         end
         vau_pkg::CMD_DOT, vau_pkg::CMD_SQMAG: begin
            p0_in.sc = sat_word(fdot4_ff);
         end
         default: begin
            p0_in = ctl4_ff;
         end
      endcase
   end

   // divisor set-up after the last root step
   always_comb begin
      logic [W-1:0] root;
      logic [W-1:0] top;
      d0_in  = ctlp_ff[SL];
      root   = sq_ff[SL].root;
      dv0_in = '0;
      dv0_in.d = (ctlp_ff[SL].cmd == vau_pkg::CMD_DIV) ? ctlp_ff[SL].smag : root;
      if (ctlp_ff[SL].cmd == vau_pkg::CMD_MAG) begin
         d0_in.sc = root[W-1] ? {1'b0, {(W-1){1'b1}}} : root;
      end
      if (ctlp_ff[SL].cmd == vau_pkg::CMD_NORM && root == '0) begin
         d0_in.err = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         top = W'(ctlp_ff[SL].amag[i][W-1:W-1-FB]);
         dv0_in.rem[i] = top;
         dv0_in.ovf[i] = (top >= dv0_in.d);
         dv0_in.lo[i]  = {ctlp_ff[SL].amag[i][W-2-FB:0], {FB{1'b0}}};
         dv0_in.neg[i] = ctlp_ff[SL].aneg[i] ^
                         ((ctlp_ff[SL].cmd == vau_pkg::CMD_DIV) && ctlp_ff[SL].sneg);
      end
   end

   // root and divide pipes, one bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= '0;
      end else if (en) begin
         vp_ff <= {vp_ff[PL-1:0], v4_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctlp_ff[0] <= p0_in;
         sq_ff[0]   <= '{rem: '0, root: '0, rad: rad4_ff};
         for (int k = 1; k <= SL; k++) begin
            ctlp_ff[k] <= ctlp_ff[k-1];
            sq_ff[k]   <= sq_step(sq_ff[k-1]);
         end
         ctlp_ff[SL+1] <= d0_in;
         dv_ff[0]      <= dv0_in;
         for (int k = 1; k <= DL; k++) begin
            ctlp_ff[SL+1+k] <= ctlp_ff[SL+k];
            dv_ff[k]        <= dv_step(dv_ff[k-1]);
         end
      end
   end

   // output stage: sign and saturate quotients, pick the result
   always_comb begin
      logic [W-1:0] q;
      q       = '0;
      rvec_in = ctlp_ff[PL].vec;
      if ((ctlp_ff[PL].cmd == vau_pkg::CMD_DIV || ctlp_ff[PL].cmd == vau_pkg::CMD_NORM)
          && !ctlp_ff[PL].err) begin
         for (int i = 0; i < 3; i++) begin
            q = {1'b0, dv_ff[DL].q[i]};
            if (dv_ff[DL].ovf[i]) begin
               rvec_in[i] = dv_ff[DL].neg[i] ? {1'b1, {(W-1){1'b0}}}
                                             : {1'b0, {(W-1){1'b1}}};
            end else begin
               rvec_in[i] = dv_ff[DL].neg[i] ? W'(-q) : q;
            end
         end
      end else if (ctlp_ff[PL].err) begin
         rvec_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vp_ff[PL];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rvec_ff <= rvec_in;
         rsc_ff  <= ctlp_ff[PL].sc;
         req_ff  <= ctlp_ff[PL].eq;
         rerr_ff <= ctlp_ff[PL].err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsc_ff, rvec_ff[2], rvec_ff[1], rvec_ff[0]};
   assign rsp_tuser  = {rerr_ff, req_ff};

endmodule

@@ design/vau_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic unit port checker
// Watches the stream ports of the vector unit over time.
// ----------------------------------------------------------------------------
module vau_check (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [vau_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic [vau_pkg::RSP_USER_BITS-1:0]  rsp_tuser
);

   // a held response word keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // a stalled output stops the request side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while output stalled");

   // an error word carries zeros and no equal flag
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[vau_pkg::USER_ERR_BIT] |->
         rsp_tdata == '0 && !rsp_tuser[vau_pkg::USER_EQ_BIT])
      else $error("error word with non-zero payload");

   // an equal verdict carries zero data
   a_eq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[vau_pkg::USER_EQ_BIT] |-> rsp_tdata == '0)
      else $error("equal word with non-zero payload");

   // reset empties the output
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind vector3_arithmetic_unit vau_check u_vau_check (.*);

@@ test/tb_vector3_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector arithmetic unit testbench
// Drives request words in random bursts against a stalling receiver, predicts
// every response with a fixed-point model of the unit and checks each
// response word field by field, across several tolerance settings.
// ----------------------------------------------------------------------------
module tb_vector3_arithmetic_unit;

   localparam int    WATCHDOG_LIMIT = 20000;
   localparam int    DRAIN_CYCLES   = 100;
   localparam int    RANDOM_WORDS   = 1400;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   typedef struct packed {
      logic [31:0] rx, ry, rz, sc;
      logic        eq, err;
   } vec_result_type;

   typedef struct {
      logic [3:0]  cmd;
      logic [31:0] a [3];
      logic [31:0] b [3];
      logic [31:0] s;
   } vec_request_type;

   // ------------------------------------------------------------------------
   // Predictor and store of expected responses
   // ------------------------------------------------------------------------
   class vector_scoreboard;
      vec_result_type pending_results [$];
      logic [30:0] tolerance = vau_pkg::TOL_RESET;
      int          error_count = 0;

      function automatic longint sat(longint v);
         if (v > MAX32) return MAX32;
         if (v < MIN32) return MIN32;
         return v;
      endfunction

      // product floored to the fixed-point grid (>>> floors)
      function automatic longint fx_mul(longint x, longint y);
         return (x * y) >>> vau_pkg::FRAC_BITS;
      endfunction

      function automatic longint fx_div(longint num, longint den);
         longint unsigned q;
         longint unsigned nm;
         longint unsigned dm;
         nm = num < 0 ? -num : num;
         dm = den < 0 ? -den : den;
         q  = (nm << vau_pkg::FRAC_BITS) / dm;
         if ((num < 0) != (den < 0))
            return q > 64'd2147483648 ? MIN32 : -longint'(q);
         return q > 64'd2147483647 ? MAX32 : longint'(q);
      endfunction

      function automatic longint unsigned floor_root(longint unsigned n);
         longint unsigned res;
         longint unsigned bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n   -= res + bitv;
               res  = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // note an accepted request word and queue its response
      function void note_request(vec_request_type q);
         longint a [3];
         longint b [3];
         longint r [3];
         longint s, sc, d;
         longint unsigned sum, m;
         logic eq, err;
         vec_result_type res;
         for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(q.a[i]));
            b[i] = longint'($signed(q.b[i]));
            r[i] = 0;
         end
         s = longint'($signed(q.s));
         sc = 0; eq = 0; err = 0;
         case (q.cmd)
            vau_pkg::CMD_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            vau_pkg::CMD_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            vau_pkg::CMD_SCALE: for (int i = 0; i < 3; i++) r[i] = fx_mul(a[i], s);
            vau_pkg::CMD_DIV: begin
               if (s == 0) err = 1;
               else for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], s);
            end
            vau_pkg::CMD_DOT:
               sc = fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]);
            vau_pkg::CMD_CROSS: begin
               r[0] = fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
               r[1] = fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
               r[2] = fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
            end
            vau_pkg::CMD_SQMAG:
               sc = fx_mul(a[0], a[0]) + fx_mul(a[1], a[1]) + fx_mul(a[2], a[2]);
            vau_pkg::CMD_MAG, vau_pkg::CMD_NORM: begin
               sum = 0;
               for (int i = 0; i < 3; i++) sum += longint'(a[i] * a[i]);
               m = floor_root(sum);
               if (q.cmd == vau_pkg::CMD_MAG)
                  sc = m > 64'd2147483647 ? MAX32 : longint'(m);
               else if (m == 0) err = 1;
               else for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], longint'(m));
            end
            vau_pkg::CMD_EQUAL: begin
               eq = 1;
               for (int i = 0; i < 3; i++) begin
                  d = a[i] - b[i];
                  if (d < 0) d = -d;
                  if (d > longint'(tolerance)) eq = 0;
               end
            end
            default: ;
         endcase
         res.rx = 32'(sat(r[0]));
         res.ry = 32'(sat(r[1]));
         res.rz = 32'(sat(r[2]));
         res.sc = 32'(sat(sc));
         res.eq = eq;
         res.err = err;
         pending_results.push_back(res);
      endfunction

      // compare a response word with the oldest expectation
      function void check_response(vec_result_type got);
         vec_result_type exp;
         if (pending_results.size() == 0) begin
            $error("response word with nothing expected");
            error_count++;
            return;
         end
         exp = pending_results.pop_front();
         if (got.rx !== exp.rx) begin
            $error("rx expected %h actual %h", exp.rx, got.rx); error_count++;
         end
         if (got.ry !== exp.ry) begin
            $error("ry expected %h actual %h", exp.ry, got.ry); error_count++;
         end
         if (got.rz !== exp.rz) begin
            $error("rz expected %h actual %h", exp.rz, got.rz); error_count++;
         end
         if (got.sc !== exp.sc) begin
            $error("scalar_out expected %h actual %h", exp.sc, got.sc); error_count++;
         end
         if (got.eq !== exp.eq) begin
            $error("is_equal expected %b actual %b", exp.eq, got.eq); error_count++;
         end
         if (got.err !== exp.err) begin
            $error("error expected %b actual %b", exp.err, got.err); error_count++;
         end
      endfunction
   endclass

   logic                              clock = 0;
   logic                              reset = 1;
   logic                              req_tvalid = 0;
   logic                              req_tready;
   logic [vau_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [vau_pkg::CMD_BITS-1:0]      req_tuser = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 0;
   logic [vau_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic [vau_pkg::RSP_USER_BITS-1:0] rsp_tuser;
   logic                              csr_wr_en = 0;
   logic [vau_pkg::TOL_BITS-1:0]      csr_wr_data = '0;

   vector_scoreboard board = new();
   int  idle_cycles = 0;
   int  burst_left  = 0;
   bit  stall_mode  = 0;

   always #6 clock = ~clock;

   vector3_arithmetic_unit i_dut (.*);

   // receiver: stall on a pattern that changes mode every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   // check response words and count idle cycles for the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_response({rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                                  rsp_tdata[127:96], rsp_tuser[vau_pkg::USER_EQ_BIT],
                                  rsp_tuser[vau_pkg::USER_ERR_BIT]});
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
         3:       return 32'($signed($urandom_range(0, 511)) - 256);
         default: return $urandom();
      endcase
   endfunction

   // send one request word, honouring the burst and gap pattern
   task automatic send_word(vec_request_type q);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tuser  <= q.cmd;
      req_tdata  <= {q.s, q.b[2], q.b[1], q.b[0], q.a[2], q.a[1], q.a[0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(q);
   endtask

   task automatic send_fields(logic [3:0] cmd, logic [31:0] ax, logic [31:0] ay,
                              logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                              logic [31:0] bz, logic [31:0] s);
      vec_request_type q;
      q.cmd = cmd;
      q.a[0] = ax; q.a[1] = ay; q.a[2] = az;
      q.b[0] = bx; q.b[1] = by; q.b[2] = bz;
      q.s = s;
      send_word(q);
   endtask

   // drain the pipe, then write the tolerance while idle
   task automatic set_tolerance(logic [30:0] value);
      req_tvalid <= 0;
      burst_left = 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      board.tolerance = value;
   endtask

   initial begin
      vec_request_type q;
      logic [30:0] tol_list [4];
      tol_list = '{31'h7FFF_FFFF, 31'd0, 31'h0001_0000, 31'h0000_0100};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every command and the special cases
      send_fields(vau_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                  32'h7FFF_FFFF, 32'h8000_0000, -1, 0);
      send_fields(vau_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                  32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
      send_fields(vau_pkg::CMD_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, -3, 0, 0, 0,
                  32'h8000_0000);
      send_fields(vau_pkg::CMD_SCALE, 32'h0001_8000, -32'h0001_8000, 5, 0, 0, 0,
                  32'hFFFF_FFFF);
      send_fields(vau_pkg::CMD_DIV, 32'h0001_0000, -7, 32'h7FFF_FFFF, 0, 0, 0, 0);
      send_fields(vau_pkg::CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, -7, 0, 0, 0, 1);
      send_fields(vau_pkg::CMD_DIV, 32'h8000_0000, 5, -5, 0, 0, 0, -32'h0001_0000);
      send_fields(vau_pkg::CMD_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_fields(vau_pkg::CMD_DOT, 32'h7FFF_FFFF, -1, 3, 32'h8000_0000, 1, -3, 0);
      send_fields(vau_pkg::CMD_CROSS, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                  32'h8000_0000, 32'h7FFF_FFFF, -1, 0);
      send_fields(vau_pkg::CMD_SQMAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  0, 0, 0, 0);
      send_fields(vau_pkg::CMD_SQMAG, -1, 1, 32'h0000_8000, 0, 0, 0, 0);
      send_fields(vau_pkg::CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  0, 0, 0, 0);
      send_fields(vau_pkg::CMD_MAG, 3, 4, 0, 0, 0, 0, 0);
      send_fields(vau_pkg::CMD_NORM, 0, 0, 0, 1, 1, 1, 1);
      send_fields(vau_pkg::CMD_NORM, 1, 0, 0, 0, 0, 0, 0);
      send_fields(vau_pkg::CMD_NORM, 32'h8000_0000, 32'h7FFF_FFFF, -1, 0, 0, 0, 0);
      send_fields(vau_pkg::CMD_EQUAL, 5, 5, 5, 6, 4, 5, 0);
      send_fields(vau_pkg::CMD_EQUAL, 5, 5, 5, 7, 5, 5, 0);
      send_fields(vau_pkg::CMD_EQUAL, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0);
      send_fields(4'd10, 1, 2, 3, 4, 5, 6, 7);
      send_fields(4'd15, -1, -1, -1, -1, -1, -1, -1);

      // random words under several tolerance settings
      for (int phase = 0; phase < 4; phase++) begin
         set_tolerance(tol_list[phase]);
         send_fields(vau_pkg::CMD_EQUAL, 32'h7FFF_FFFF, 0, 5, 32'h8000_0000, 0, 5, 0);
         for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
            q.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
            for (int i = 0; i < 3; i++) begin
               q.a[i] = rand_word();
               q.b[i] = ($urandom_range(0, 2) == 0) ? q.a[i] + 32'($urandom_range(0, 4) - 2)
                                                    : rand_word();
            end
            q.s = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_word();
            if (q.cmd == vau_pkg::CMD_NORM && $urandom_range(0, 9) == 0) q.a = '{0, 0, 0};
            send_word(q);
         end
      end

      // drain and finish
      req_tvalid <= 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
design/vau_pkg.sv
design/vector3_arithmetic_unit.sv
design/vau_check.sv
test/tb_vector3_arithmetic_unit.sv
